// ===== rtl/core/pem_pkg.sv =====
// Shared constants and helpers for the Prewitt edge magnitude unit.
package pem_pkg;

  // Default size limits of the line stores and row counters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Pixel and register field widths
  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // Register reset values and smallest usable frame dimension
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd300;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd246;
  localparam int                      MIN_DIM      = 3;

  // Register indexes (word address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // Absolute difference of two 3-pixel sums, clamped to a pixel value
  function automatic logic [PIX_W-1:0] abs_clamp(input logic [PIX_W+1:0] a,
                                                 input logic [PIX_W+1:0] b);
    logic [PIX_W+1:0] d;
    begin
      d = (a >= b) ? (a - b) : (b - a);
      abs_clamp = (d > {2'b00, PIX_MAX}) ? PIX_MAX : d[PIX_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/prewitt_edge_magnitude_unit.sv =====
// Prewitt edge magnitude over a raster pixel stream, with line stores and APB registers.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  sample   | sample_valid sample_stall kind pixel      | in
//  result   | result_valid result_stall magnitude last  | out
//  config   | psel penable pwrite paddr pwdata prdata   | APB slave
//
// A producing item passes accept, line store read and window shift, gradient, square sum,
// nine steps of the square root unit and result load. An item that gives no result ends
// after the line store read and window shift; an ignored flush item is only accepted.
// Reset clears counters, window and control; the line stores hold garbage until written.
// A stalled result waits in the output register; the next item is taken meanwhile.
module prewitt_edge_magnitude_unit #(
  parameter int MAX_WIDTH  = pem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample channel
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic                           kind,
  input  logic [pem_pkg::PIX_W-1:0]      pixel,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [pem_pkg::PIX_W-1:0]      magnitude,
  output logic                           last,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pem_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pem_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pem_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pem_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WEW  = $clog2(MAX_WIDTH + 1);
  localparam int HEW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 2);
  localparam int WCMP = (WEW > WIDTH_REG_W) ? WEW : WIDTH_REG_W;
  localparam int HCMP = (HEW > HEIGHT_REG_W) ? HEW : HEIGHT_REG_W;
  localparam int SQW  = 2 * PIX_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]              state;
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [CW-1:0]           in_column;
  logic [RW-1:0]           in_row;
  logic [CW-1:0]           out_column;
  logic [RW-1:0]           out_row;

  logic [PIX_W-1:0]        bank0 [MAX_WIDTH];
  logic [PIX_W-1:0]        bank1 [MAX_WIDTH];
  logic [PIX_W-1:0]        rd0;
  logic [PIX_W-1:0]        rd1;
  logic [CW-1:0]           addr_q;
  logic [PIX_W-1:0]        px_q;
  logic [PIX_W-1:0]        win [9];

  logic [PIX_W-1:0]        ax;
  logic [PIX_W-1:0]        ay;
  logic [SQW-1:0]          rem;
  logic [SQW-1:0]          res;
  logic [SQW-1:0]          rbit;

  logic                    cfg_write;
  logic                    sample_accept;
  logic                    result_take;
  logic                    pixel_slot;
  logic                    ignore_item;
  logic                    produce;
  logic                    border;
  logic                    last_flag;
  logic                    out_free;
  logic [WEW-1:0]          w_eff;
  logic [HEW-1:0]          h_eff;
  logic [RW-1:0]           h_ext;
  logic [RW-1:0]           h_m1;
  logic [WEW-1:0]          w_m1;
  logic [WEW-1:0]          col_inc;
  logic [WEW-1:0]          out_col_ext;
  logic [WEW-1:0]          out_col_inc;
  logic [WCMP-1:0]         w_raw;
  logic [HCMP-1:0]         h_raw;
  logic [PIX_W+1:0]        sum_l;
  logic [PIX_W+1:0]        sum_r;
  logic [PIX_W+1:0]        sum_t;
  logic [PIX_W+1:0]        sum_b;
  logic [2*PIX_W-1:0]      sq_x;
  logic [2*PIX_W-1:0]      sq_y;
  logic [SQW:0]            trial;

  // Handshakes
  assign pready        = 1'b1;
  assign cfg_write     = psel & penable & pwrite & pready;
  assign sample_stall  = (state != S_IDLE);
  assign sample_accept = sample_valid & ~sample_stall;
  assign result_take   = result_valid & ~result_stall;
  assign out_free      = ~result_valid | ~result_stall;

  // Clamp the frame size registers to the usable range
  always_comb begin
    w_raw = WCMP'(image_width);
    h_raw = HCMP'(image_height);
    if (w_raw < WCMP'(MIN_DIM)) begin
      w_eff = WEW'(MIN_DIM);
    end else if (w_raw > WCMP'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(w_raw);
    end
    if (h_raw < HCMP'(MIN_DIM)) begin
      h_eff = HEW'(MIN_DIM);
    end else if (h_raw > HCMP'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(h_raw);
    end
  end

  assign h_ext       = RW'(h_eff);
  assign h_m1        = h_ext - RW'(1);
  assign w_m1        = w_eff - WEW'(1);
  assign col_inc     = WEW'(in_column) + WEW'(1);
  assign out_col_ext = WEW'(out_column);
  assign out_col_inc = out_col_ext + WEW'(1);

  // Slot classification of the offered item
  assign pixel_slot  = (in_row < h_ext);
  assign ignore_item = pixel_slot & (kind == KIND_FLUSH);
  assign produce     = (in_row >= RW'(2)) | ((in_row == RW'(1)) & (in_column != '0));

  // Window sums and border test
  assign sum_l = 10'(win[0]) + 10'(win[3]) + 10'(win[6]);
  assign sum_r = 10'(win[2]) + 10'(win[5]) + 10'(win[8]);
  assign sum_t = 10'(win[0]) + 10'(win[1]) + 10'(win[2]);
  assign sum_b = 10'(win[6]) + 10'(win[7]) + 10'(win[8]);
  assign border = (out_row == '0) | (out_column == '0) | (out_row >= h_m1) |
                  (out_col_ext >= w_m1);
  assign last_flag = (out_row >= h_m1) & (out_col_ext >= w_m1);

  assign sq_x  = ax * ax;
  assign sq_y  = ay * ay;
  assign trial = (SQW+1)'(res) + (SQW+1)'(rbit);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_HEIGHT: prdata = APB_DATA_W'(image_height);
    endcase
  end

  // Line stores: read the current column, write back during the window shift
  always_ff @(posedge clk) begin
    rd0 <= bank0[in_column];
    rd1 <= bank1[in_column];
    if (state == S_READ) begin
      bank0[addr_q] <= px_q;
      bank1[addr_q] <= rd0;
    end
  end

  // Sequencer, counters and window
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_accept && !ignore_item) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // shift the window left, new column on the right
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= rd1;
          win[3] <= win[4];
          win[4] <= win[5];
          win[5] <= rd0;
          win[6] <= win[7];
          win[7] <= win[8];
          win[8] <= px_q;
          if (col_inc >= w_eff) begin
            in_column <= '0;
            in_row    <= in_row + RW'(1);
          end else begin
            in_column <= CW'(col_inc);
          end
          state <= produce ? S_GRAD : S_IDLE;
        end
        S_GRAD: state <= S_SQR;
        S_SQR:  state <= S_ROOT;
        S_ROOT: begin
          if (rbit[0]) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            if (last_flag) begin
              in_column  <= '0;
              in_row     <= '0;
              out_column <= '0;
              out_row    <= '0;
            end else if (out_col_inc >= w_eff) begin
              out_column <= '0;
              out_row    <= out_row + RW'(1);
            end else begin
              out_column <= CW'(out_col_inc);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // a register write restarts the frame
      if (cfg_write) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end
    end
  end

  // Item capture, gradients and square root datapath
  always_ff @(posedge clk) begin
    if (sample_accept) begin
      px_q   <= pixel_slot ? pixel : '0;
      addr_q <= in_column;
    end
    if (state == S_GRAD) begin
      if (border) begin
        ax <= win[4];
        ay <= win[4];
      end else begin
        ax <= abs_clamp(sum_r, sum_l);
        ay <= abs_clamp(sum_b, sum_t);
      end
    end
    if (state == S_SQR) begin
      rem  <= SQW'(sq_x) + SQW'(sq_y);
      res  <= '0;
      rbit <= SQW'(1) << (SQW - 1);
    end
    // one digit of the restoring square root per cycle
    if (state == S_ROOT) begin
      if ((SQW+1)'(rem) >= trial) begin
        rem <= rem - trial[SQW-1:0];
        res <= (res >> 1) + rbit;
      end else begin
        res <= res >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      magnitude <= (res > SQW'(PIX_MAX)) ? PIX_MAX : res[PIX_W-1:0];
      last      <= last_flag;
    end
  end

`ifndef SYNTHESIS
  // a new result appears only out of the final sequencer step
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the final step");

  // input row never runs past the flush rows
  assert property (@(posedge clk) disable iff (rst)
    in_row <= h_ext + RW'(1))
    else $error("input row counter out of range");

  // output position stays inside the frame
  assert property (@(posedge clk) disable iff (rst)
    (out_row < h_ext) && (out_col_ext < w_eff))
    else $error("output position out of range");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the Prewitt edge magnitude unit: predicts every result and checks it beat by beat.
module tb_top;
  import pem_pkg::*;

  localparam int          MAXW          = DEF_MAX_WIDTH;
  localparam int          MAXH          = DEF_MAX_HEIGHT;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int          SETTLE_CYCLES = 30;
  localparam int unsigned RANDOM_BEATS  = 400;
  localparam int          REPORT_MAX    = 40;

  typedef struct packed {
    logic [PIX_W-1:0] mag;
    logic             last;
  } mag_beat_t;

  typedef enum int {
    STYLE_UNIFORM,
    STYLE_BINARY,
    STYLE_RAMP,
    STYLE_CORNER,
    STYLE_ROW_STEP
  } pix_style_t;

  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_RUNS,
    STALL_HALF
  } stall_mode_t;

  // DUT ports
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic                  kind         = KIND_PIXEL;
  logic [PIX_W-1:0]      pixel        = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [PIX_W-1:0]      magnitude;
  logic                  last;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state
  logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
  logic [PIX_W-1:0]        line_buf [0:2*MAXW-1];
  logic [PIX_W-1:0]        win [0:8];
  int unsigned             col_in  = 0;
  int unsigned             row_in  = 0;
  int unsigned             col_out = 0;
  int unsigned             row_out = 0;

  mag_beat_t   expected_mags [$];
  int unsigned cycle_count = 0;
  int          fail_count  = 0;
  int unsigned beats_sent  = 0;

  // Sender pacing
  int unsigned burst_left = 0;
  int unsigned burst_max  = 8;
  int unsigned gap_max    = 4;

  // Receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned run_left   = 0;
  logic        run_level  = 1'b0;

  prewitt_edge_magnitude_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .kind         (kind),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .magnitude    (magnitude),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(cfg_width);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(cfg_height);
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAXH) h = MAXH;
    return h;
  endfunction

  // Any register write starts a fresh frame; line buffers and window keep their data
  function automatic void apply_reg_write(input logic idx, input logic [APB_DATA_W-1:0] data);
    if (idx == REG_WIDTH) begin
      cfg_width = data[WIDTH_REG_W-1:0];
    end else begin
      cfg_height = data[HEIGHT_REG_W-1:0];
    end
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  function automatic int unsigned grad_abs(input int g);
    int unsigned a;
    a = (g < 0) ? -g : g;
    return (a > PIX_MAX) ? PIX_MAX : a;
  endfunction

  // Largest root whose square fits, capped at the pixel maximum
  function automatic logic [PIX_W-1:0] root_clamped(input int unsigned v);
    int unsigned r;
    r = 0;
    while (r < PIX_MAX && (r + 1) * (r + 1) <= v) r++;
    return r[PIX_W-1:0];
  endfunction

  function automatic bit predict_magnitude(input logic k, input logic [PIX_W-1:0] p,
                                           output mag_beat_t beat);
    int unsigned      w, h, c, ax, ay;
    logic [PIX_W-1:0] px, up1, up2;
    int               gx, gy;
    bit               gives;
    w    = eff_width();
    h    = eff_height();
    beat = '0;
    // Flush while pixels are still due is dropped; in the drain phase the pixel is zero
    if (row_in < h) begin
      if (k == KIND_FLUSH) return 1'b0;
      px = p;
    end else begin
      px = '0;
    end
    c   = (col_in >= MAXW) ? MAXW - 1 : col_in;
    up1 = line_buf[c];
    up2 = line_buf[MAXW + c];
    // Shift the window left and load the new column on the right
    win[0] = win[1]; win[1] = win[2]; win[2] = up2;
    win[3] = win[4]; win[4] = win[5]; win[5] = up1;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    line_buf[MAXW + c] = up1;
    line_buf[c]        = px;
    gives = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (!gives) return 1'b0;
    if (row_out == 0 || col_out == 0 || row_out >= h - 1 || col_out >= w - 1) begin
      ax = 32'(win[4]);
      ay = 32'(win[4]);
    end else begin
      gx = (int'(win[2]) + win[5] + win[8]) - (int'(win[0]) + win[3] + win[6]);
      gy = (int'(win[6]) + win[7] + win[8]) - (int'(win[0]) + win[1] + win[2]);
      ax = grad_abs(gx);
      ay = grad_abs(gy);
    end
    beat.mag  = root_clamped(ax * ax + ay * ay);
    beat.last = (row_out >= h - 1 && col_out >= w - 1);
    if (beat.last) begin
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checker

  // Check the result beat first, then predict from the sample beat of the same edge
  always @(posedge clk) begin : check_results
    mag_beat_t want;
    mag_beat_t fresh;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_mags.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $error("unexpected beat: magnitude %0d last %0d", magnitude, last);
          fail_count++;
        end else begin
          want = expected_mags.pop_front();
          if (magnitude !== want.mag) begin
            if (fail_count < REPORT_MAX)
              $error("magnitude: expected %0d, got %0d", want.mag, magnitude);
            fail_count++;
          end
          if (last !== want.last) begin
            if (fail_count < REPORT_MAX)
              $error("last: expected %0d, got %0d", want.last, last);
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        if (predict_magnitude(kind, pixel, fresh)) expected_mags.push_back(fresh);
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Switch to a randomly chosen stall pattern when the current one runs out
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE: begin
        result_stall <= 1'b0;
      end
      STALL_SPARSE: begin
        result_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_level = ~run_level;
          run_left  = $urandom_range(1, 20);
        end
        run_left--;
        result_stall <= run_level;
      end
      default: begin
        result_stall <= ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  // ---------------------------------------------------------------- drivers

  task automatic set_pacing(input int unsigned bmax, input int unsigned gmax);
    burst_max  = bmax;
    gap_max    = gmax;
    burst_left = 0;
  endtask

  task automatic random_pacing();
    case ($urandom_range(0, 3))
      0:       set_pacing(100000, 1);
      1:       set_pacing(4, 16);
      2:       set_pacing(12, 6);
      default: set_pacing(32, 2);
    endcase
  endtask

  // Drive one sample beat and hold it until accepted
  task automatic send_beat(input logic k, input logic [PIX_W-1:0] p);
    int unsigned gap;
    if (burst_left == 0) begin
      sample_valid <= 1'b0;
      gap = $urandom_range(1, gap_max);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
    sample_valid <= 1'b1;
    kind         <= k;
    pixel        <= p;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Drop valid, drain every expected beat, then let trailing work settle
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(negedge clk);
    while (expected_mags.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic reg_write(input logic idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg_write(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_read(input logic idx, input logic [APB_DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      if (fail_count < REPORT_MAX)
        $error("prdata: expected 0x%0h, got 0x%0h", want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] frame_pixel(input pix_style_t style,
                                                   input int unsigned col, input int unsigned row,
                                                   input int unsigned w, input int unsigned h);
    int unsigned v;
    case (style)
      STYLE_BINARY:   v = $urandom_range(0, 1) ? PIX_MAX : 0;
      STYLE_RAMP:     v = col * 9 + row * 5 + $urandom_range(0, 6);
      STYLE_CORNER:   v = (row == h - 1 || col == w - 1) ? PIX_MAX : 0;
      STYLE_ROW_STEP: v = (row == 0) ? PIX_MAX : (row == 1) ? 7 : 0;
      default:        v = $urandom_range(0, 255);
    endcase
    return v[PIX_W-1:0];
  endfunction

  // Send one frame at the current size, then the drain beats; stop early when asked
  task automatic run_frame(input pix_style_t style, input int stop_after,
                           input int unsigned noise_pct, input int unsigned drain_pix_pct);
    int unsigned w, h, r, c, i;
    int          n;
    logic        k;
    w = eff_width();
    h = eff_height();
    n = 0;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (stop_after >= 0 && n == stop_after) return;
        if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
          send_beat(KIND_FLUSH, PIX_W'($urandom_range(0, 255)));
        send_beat(KIND_PIXEL, frame_pixel(style, c, r, w, h));
        n++;
        beats_sent++;
      end
    end
    for (i = 0; i <= w; i++) begin
      k = ($urandom_range(1, 100) <= drain_pix_pct) ? KIND_PIXEL : KIND_FLUSH;
      send_beat(k, PIX_W'($urandom_range(0, 255)));
      beats_sent++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_defaults();
    reg_read(REG_WIDTH, APB_DATA_W'(WIDTH_RESET));
    reg_read(REG_HEIGHT, APB_DATA_W'(HEIGHT_RESET));
  endtask

  // Smallest frame via clamped sizes; flush at frame start is dropped,
  // pixel beats in the drain phase count as flushes
  task automatic test_small_frames();
    set_pacing(4, 8);
    reg_write(REG_WIDTH, 0);
    reg_write(REG_HEIGHT, 2);
    send_beat(KIND_FLUSH, 8'h5A);
    run_frame(STYLE_CORNER, -1, 0, 0);
    send_beat(KIND_FLUSH, PIX_MAX);
    run_frame(STYLE_ROW_STEP, -1, 0, 100);
    wait_idle();
  endtask

  // All-ones register values clamp to the widest and tallest frames;
  // the large frames are cut short; the last one runs past its first clamped row
  task automatic test_register_extremes();
    reg_write(REG_WIDTH, '1);
    reg_write(REG_HEIGHT, '1);
    reg_read(REG_WIDTH, APB_DATA_W'(cfg_width));
    reg_read(REG_HEIGHT, APB_DATA_W'(cfg_height));
    set_pacing(16, 4);
    run_frame(STYLE_UNIFORM, 40, 0, 0);
    wait_idle();
    // Narrow and tall: height stays at its clamp
    reg_write(REG_WIDTH, MIN_DIM);
    set_pacing(64, 3);
    run_frame(STYLE_UNIFORM, 240, 2, 20);
    wait_idle();
    reg_write(REG_WIDTH, '1);
    reg_write(REG_HEIGHT, MIN_DIM);
    run_frame(STYLE_BINARY, 1040, 2, 20);
    wait_idle();
  endtask

  // Cut a frame short, then restart it with a height-only write
  task automatic test_mid_frame_restart();
    set_pacing(6, 10);
    reg_write(REG_WIDTH, 6);
    reg_write(REG_HEIGHT, 5);
    run_frame(STYLE_RAMP, 20, 5, 0);
    wait_idle();
    reg_write(REG_HEIGHT, 4);
    run_frame(STYLE_BINARY, -1, 5, 20);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start, w_val, h_val, span;
    bit          cut, wide;
    int          stop;
    start = beats_sent;
    cut   = 1'b0;
    while (beats_sent - start < RANDOM_BEATS) begin
      // Resize after a cut frame and most of the time otherwise
      if (cut || $urandom_range(0, 7) != 0) begin
        wide  = ($urandom_range(0, 7) == 0);
        w_val = wide ? $urandom_range(13, 64) : $urandom_range(3, 12);
        h_val = wide ? $urandom_range(3, 4) : $urandom_range(3, 10);
        if ($urandom_range(0, 9) == 0) w_val = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) h_val = $urandom_range(0, 2);
        wait_idle();
        case ($urandom_range(0, 3))
          0: reg_write(REG_WIDTH, w_val);
          1: reg_write(REG_HEIGHT, h_val);
          2: begin
            reg_write(REG_HEIGHT, h_val);
            reg_write(REG_WIDTH, w_val);
          end
          default: begin
            reg_write(REG_WIDTH, w_val);
            reg_write(REG_HEIGHT, h_val);
          end
        endcase
      end
      random_pacing();
      cut  = ($urandom_range(0, 9) == 0);
      span = eff_width() * eff_height();
      stop = cut ? $urandom_range(1, span - 1) : -1;
      run_frame(pix_style_t'($urandom_range(0, 2)), stop, 4, 20);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int i = 0; i < 2 * MAXW; i++) line_buf[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_register_defaults();
    test_small_frames();
    test_register_extremes();
    test_mid_frame_restart();
    test_random_frames();
    if (fail_count == 0 && expected_mags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pem_pkg.sv
rtl/core/prewitt_edge_magnitude_unit.sv
tb/sv/tb_top.sv
